@@ sv/fbp_pkg.sv @@
// Shared types and codes of the fixed block pool free list.
`timescale 1ns / 1ps
`default_nettype none
package fbp_pkg;

	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADCFG = 2'd2;
	localparam logic [1:0] ST_NOINIT = 2'd3;

	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_SIZE  = 2'd2;

	localparam int IN_W  = 16;
	localparam int OUT_W = 48;

	typedef struct packed {
		logic [31:0] base_address;
		logic [8:0]  block_count;
		logic [15:0] block_size;
	} cfg_t;

	typedef struct packed {
		logic [31:0] block_address;
		logic [7:0]  block_index;
		logic [1:0]  status;
	} result_t;

endpackage
`default_nettype wire

@@ sv/fbp_link_mem.sv @@
// Link memory of the free list: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fbp_link_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata_q
);

	logic [DW-1:0] link_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= link_mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/fbp_ctrl.sv @@
// Command sequencer: free list head, init walk, alloc read and address calculation.
`timescale 1ns / 1ps
`default_nettype none
module fbp_ctrl #(
	parameter int MAX_BLOCKS = 256,
	parameter int IW         = 8,
	parameter int LW         = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fbp_pkg::cfg_t    cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire logic [7:0]       free_index,
	input  wire logic [1:0]       buf_level,
	output logic                  res_valid,
	output fbp_pkg::result_t      res,
	output logic                  mem_we,
	output logic [IW-1:0]         mem_waddr,
	output logic [LW-1:0]         mem_wdata,
	output logic                  mem_re,
	output logic [IW-1:0]         mem_raddr,
	input  wire logic [LW-1:0]    mem_rdata
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_ALLOC = 2'd2;

	localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);
	localparam int PW = IW + 16;

	logic [1:0]        state_q;
	logic [LW-1:0]     head_q;
	logic              ready_q;
	logic [IW-1:0]     cnt_q;
	logic              res_valid_q;
	fbp_pkg::result_t  res_q;
	logic [31:0]       held_base_q;
	logic [15:0]       held_size_q;
	logic [IW-1:0]     idx_s1;
	logic [31:0]       prod_s1;

	logic              acc;
	logic              cfg_bad;
	logic              head_null;
	logic              fidx_ok;
	logic              walk_last;
	logic [IW-1:0]     head_idx;
	logic [PW-1:0]     prod;
	logic              res_set;
	fbp_pkg::result_t  res_nxt;

	assign in_ready  = (state_q == S_IDLE)
		&& (({1'b0, buf_level} + {2'b00, res_valid_q}) < 3'd2);
	assign acc       = in_valid && in_ready;
	assign cfg_bad   = (cfg.base_address == 32'd0) || (cfg.block_count == 9'd0)
		|| (cfg.block_size == 16'd0) || (32'(cfg.block_count) > MAX_BLOCKS);
	assign head_null = 32'(head_q) >= MAX_BLOCKS;
	assign fidx_ok   = 32'(free_index) < MAX_BLOCKS;
	assign walk_last = 32'(cnt_q) == (32'(cfg.block_count) - 32'd1);
	assign head_idx  = head_q[IW-1:0];
	assign prod      = PW'(head_idx) * PW'(held_size_q);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = LINK_NULL;
		mem_re    = 1'b0;
		mem_raddr = head_idx;
		if (state_q == S_WALK) begin
			mem_we = 1'b1;
			if (cnt_q != '0) begin
				mem_wdata = LW'(cnt_q - 1'b1);
			end
		end
		if (acc && ready_q && (command == fbp_pkg::CMD_ALLOC) && !head_null) begin
			mem_re = 1'b1;
		end
		if (acc && ready_q && (command == fbp_pkg::CMD_FREE) && fidx_ok) begin
			mem_we    = 1'b1;
			mem_waddr = IW'(free_index);
			mem_wdata = head_q;
		end
	end

	always_comb begin
		res_set = 1'b0;
		res_nxt = '0;
		res_nxt.status = fbp_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (command)
						fbp_pkg::CMD_INIT: begin
							if (cfg_bad) begin
								res_set        = 1'b1;
								res_nxt.status = fbp_pkg::ST_BADCFG;
							end
						end
						fbp_pkg::CMD_ALLOC: begin
							if (!ready_q) begin
								res_set        = 1'b1;
								res_nxt.status = fbp_pkg::ST_NOINIT;
							end else if (head_null) begin
								res_set        = 1'b1;
								res_nxt.status = fbp_pkg::ST_EMPTY;
							end
						end
						fbp_pkg::CMD_FREE: begin
							res_set        = 1'b1;
							res_nxt.status = ready_q ? fbp_pkg::ST_OK : fbp_pkg::ST_NOINIT;
						end
						default: begin
							res_set = 1'b1;
						end
					endcase
				end
			end
			S_WALK: begin
				res_set = walk_last;
			end
			S_ALLOC: begin
				res_set               = 1'b1;
				res_nxt.block_index   = 8'(idx_s1);
				res_nxt.block_address = held_base_q + prod_s1;
			end
			default: begin
				res_set = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= LINK_NULL;
			ready_q     <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_set;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (command)
							fbp_pkg::CMD_INIT: begin
								if (!cfg_bad) begin
									state_q <= S_WALK;
									cnt_q   <= '0;
								end
							end
							fbp_pkg::CMD_ALLOC: begin
								if (ready_q && !head_null) begin
									state_q <= S_ALLOC;
								end
							end
							fbp_pkg::CMD_FREE: begin
								if (ready_q && fidx_ok) begin
									head_q <= LW'(free_index);
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WALK: begin
					cnt_q <= cnt_q + 1'b1;
					if (walk_last) begin
						state_q <= S_IDLE;
						head_q  <= LW'(cnt_q);
						ready_q <= 1'b1;
					end
				end
				S_ALLOC: begin
					state_q <= S_IDLE;
					head_q  <= mem_rdata;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			res_q <= res_nxt;
		end
		if ((state_q == S_IDLE) && acc && (command == fbp_pkg::CMD_ALLOC)) begin
			idx_s1  <= head_idx;
			prod_s1 <= 32'(prod);
		end
		if ((state_q == S_WALK) && walk_last) begin
			held_base_q <= cfg.base_address;
			held_size_q <= cfg.block_size;
		end
	end

endmodule
`default_nettype wire

@@ sv/fbp_out_buf.sv @@
// Two-entry result queue in front of the output stream.
`timescale 1ns / 1ps
`default_nettype none
module fbp_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire fbp_pkg::result_t  push_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output fbp_pkg::result_t       out_data,
	output logic [1:0]             level
);

	fbp_pkg::result_t ent_q [2];
	logic             rd_ptr_q;
	logic             wr_ptr_q;
	logic [1:0]       level_q;
	logic             pop;

	assign out_valid = level_q != 2'd0;
	assign out_data  = ent_q[rd_ptr_q];
	assign level     = level_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ sv/fixed_block_pool_free_list.sv @@
// Top level of the fixed block pool free list allocator.
// Fixed-size block pool kept as a LIFO free list in a link memory. Each input
// transfer carries one command (init, alloc or free) and yields exactly one
// result transfer. Free, the unused command and any rejected command are
// answered from the idle state; alloc goes on to the alloc state, in which the
// registered link read gives the next head; a valid init walks the link memory,
// one link write per block. Up to two results are held at the output, so work
// goes on while the sink stalls. Configuration writes are taken at any time but
// are meant for idle periods; init latches base and size for later allocs.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_pool_free_list #(
	parameter int MAX_BLOCKS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // command[1:0], free_index[9:2], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // status[1:0], block_index[9:2], block_address[41:10]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int LW = $clog2(MAX_BLOCKS + 1);

	fbp_pkg::cfg_t    cfg_q;
	fbp_pkg::result_t res;
	fbp_pkg::result_t out_data;
	logic             res_valid;
	logic [1:0]       buf_level;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [LW-1:0]    mem_wdata;
	logic             mem_re;
	logic [IW-1:0]    mem_raddr;
	logic [LW-1:0]    mem_rdata;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {6'd0, out_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fbp_pkg::REG_BASE:  cfg_q.base_address <= cfg_data;
				fbp_pkg::REG_COUNT: cfg_q.block_count  <= cfg_data[8:0];
				fbp_pkg::REG_SIZE:  cfg_q.block_size   <= cfg_data[15:0];
				default:            cfg_q              <= cfg_q;
			endcase
		end
	end

	fbp_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IW         (IW),
		.LW         (LW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.command    (s_tdata[1:0]),
		.free_index (s_tdata[9:2]),
		.buf_level  (buf_level),
		.res_valid  (res_valid),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	fbp_link_mem #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IW),
		.DW    (LW)
	) u_link_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	fbp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.level     (buf_level)
	);

endmodule
`default_nettype wire

@@ sv/fbp_checker.sv @@
// Port-level checks of the fixed block pool free list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fbp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transfer dropped or changed while stalled");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tvalid, s_tready, m_tvalid, m_tready}))
		else $error("handshake signal unknown");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != fbp_pkg::ST_OK) |-> m_tdata[41:2] == 40'd0)
		else $error("error result carries an index or address");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:42] == 6'd0)
		else $error("result padding not zero");

endmodule

bind fixed_block_pool_free_list fbp_checker u_fbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
